@@ src/phm_pkg.sv @@
// phm_pkg: shared constants for the polynomial string hash block
// no dependencies; used by every module under src
`timescale 1ns / 1ps

package phm_pkg;

  localparam int HASH_WIDTH_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF  = 2;
  localparam int HASH_BASE        = 37;

  localparam int CHAR_W           = 8;
  localparam int RAW_W            = 32;
  localparam int BUCKET_W         = 20;
  localparam int TABLE_SIZE_W     = 21;

  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = TABLE_SIZE_W'(1024);
  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_MAX   = TABLE_SIZE_W'(1048576);

endpackage

@@ src/polynomial_string_hash_mod_core.sv @@
// polynomial_string_hash_mod_core: top level of the base-37 word hash with bucket index
// depends on phm_pkg, phm_front, phm_queue, phm_back
//
//   channel   handshake              payload
//   input     push / full            char_code, last_char, no_char
//   result    empty / pop            raw_hash, bucket
//   config    cfg_valid / cfg_ready  table_size
//
// the front takes one item per cycle while the hash queue has room
// each word's bucket is worked out bit by bit in the serial modulo unit of the back
// full rises only when the hash queue holds QUEUE_DEPTH words waiting for that unit
// a result stays on the ports until popped; the back holds its next word meanwhile
// synchronous reset clears the accumulator, queue and result valid flag; table_size resets to 1024
`timescale 1ns / 1ps

module polynomial_string_hash_mod_core #(
  parameter int HASH_WIDTH  = phm_pkg::HASH_WIDTH_DEF,
  parameter int QUEUE_DEPTH = phm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [phm_pkg::CHAR_W-1:0]        char_code,
  input  logic                              last_char,
  input  logic                              no_char,
  output logic                              empty,
  input  logic                              pop,
  output logic [phm_pkg::RAW_W-1:0]         raw_hash,
  output logic [phm_pkg::BUCKET_W-1:0]      bucket,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [phm_pkg::TABLE_SIZE_W-1:0]  table_size
);

  logic [phm_pkg::TABLE_SIZE_W-1:0] size_cfg;
  logic                             q_push;
  logic [HASH_WIDTH-1:0]            q_wdata;
  logic                             q_full;
  logic                             q_pop;
  logic [HASH_WIDTH-1:0]            q_rdata;
  logic                             q_valid;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= phm_pkg::TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= table_size;
    end
  end

  phm_front #(
    .HASH_WIDTH (HASH_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .last_char (last_char),
    .no_char   (no_char),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  phm_queue #(
    .WIDTH (HASH_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .valid   (q_valid)
  );

  phm_back #(
    .HASH_WIDTH (HASH_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .size_cfg (size_cfg),
    .empty    (empty),
    .pop      (pop),
    .raw_hash (raw_hash),
    .bucket   (bucket)
  );

endmodule

@@ src/phm_front.sv @@
// phm_front: horner accumulator, takes one character per accepted item unless no_char is set
// depends on phm_pkg; pushes finished word hashes into phm_queue
`timescale 1ns / 1ps

module phm_front #(
  parameter int HASH_WIDTH = phm_pkg::HASH_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic [phm_pkg::CHAR_W-1:0]    char_code,
  input  logic                          last_char,
  input  logic                          no_char,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [HASH_WIDTH-1:0]         q_data
);

  logic [HASH_WIDTH-1:0] acc;
  logic [HASH_WIDTH-1:0] acc_step;
  logic [HASH_WIDTH-1:0] acc_next;
  logic                  accept;

  assign accept   = push && !q_full;
  assign acc_step = HASH_WIDTH'(acc * HASH_WIDTH'(phm_pkg::HASH_BASE))
                    + HASH_WIDTH'(char_code);
  assign acc_next = no_char ? acc : acc_step;

  assign q_push = accept && last_char;
  assign q_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (accept) begin
      if (last_char) begin
        acc <= '0;
      end else begin
        acc <= acc_next;
      end
    end
  end

endmodule

@@ src/phm_queue.sv @@
// phm_queue: short fifo of finished word hashes between front and back
// depends on phm_pkg for default sizes
`timescale 1ns / 1ps

module phm_queue #(
  parameter int WIDTH = phm_pkg::HASH_WIDTH_DEF,
  parameter int DEPTH = phm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign valid   = (count != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ src/phm_back.sv @@
// phm_back: bit-serial restoring modulo of each word hash, plus result register
// depends on phm_pkg; reads phm_queue, drives the result side of the core
`timescale 1ns / 1ps

module phm_back #(
  parameter int HASH_WIDTH = phm_pkg::HASH_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  logic [HASH_WIDTH-1:0]             q_data,
  output logic                              q_pop,
  input  logic [phm_pkg::TABLE_SIZE_W-1:0]  size_cfg,
  output logic                              empty,
  input  logic                              pop,
  output logic [phm_pkg::RAW_W-1:0]         raw_hash,
  output logic [phm_pkg::BUCKET_W-1:0]      bucket
);

  localparam int CNT_W = $clog2(HASH_WIDTH + 1);
  localparam int TW    = phm_pkg::TABLE_SIZE_W;
  localparam int BW    = phm_pkg::BUCKET_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [HASH_WIDTH-1:0] hash;
  logic [HASH_WIDTH-1:0] dividend;
  logic [BW-1:0]         rem;
  logic [CNT_W-1:0]      cnt;
  logic [TW-1:0]         modulus;
  logic [TW-1:0]         rem_shift;
  logic [BW-1:0]         rem_step;
  logic                  out_valid;
  logic                  out_free;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // effective modulus: zero acts as one, large sizes saturate
  always_comb begin
    if (size_cfg == '0) begin
      modulus = TW'(1);
    end else if (size_cfg > phm_pkg::TABLE_SIZE_MAX) begin
      modulus = phm_pkg::TABLE_SIZE_MAX;
    end else begin
      modulus = size_cfg;
    end
  end

  assign rem_shift = {rem, dividend[HASH_WIDTH-1]};
  assign rem_step  = (rem_shift >= modulus) ? BW'(rem_shift - modulus) : BW'(rem_shift);

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt == CNT_W'(1)) begin
          state_next = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && q_valid) begin
        cnt <= CNT_W'(HASH_WIDTH);
      end else if (state == S_DIV) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (state == S_HOLD && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      hash     <= q_data;
      dividend <= q_data;
      rem      <= '0;
    end else if (state == S_DIV) begin
      dividend <= {dividend[HASH_WIDTH-2:0], 1'b0};
      rem      <= rem_step;
    end
    if (state == S_HOLD && out_free) begin
      raw_hash <= phm_pkg::RAW_W'(hash);
      bucket   <= rem;
    end
  end

endmodule
